// File: src/cna_pkg.sv
package cna_pkg;

  // Fixed-point format and derived datapath widths.
  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int NUM_W     = SUM_W + FRAC_BITS;
  localparam int DEN_W     = PROD_W;
  localparam int QUO_W     = DATA_W + 1;
  localparam int SH_W      = DEN_W + QUO_W - 1;
  localparam int CMP_W     = DEN_W + QUO_W;

  // Operation select codes.
  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  // State of both division lanes between two quotient steps.
  typedef struct packed {
    logic [SH_W-1:0]  dsh;
    logic [NUM_W-1:0] rem_re;
    logic [NUM_W-1:0] rem_im;
    logic [QUO_W-1:0] quo_re;
    logic [QUO_W-1:0] quo_im;
  } div_t;

endpackage

// File: src/cna_div_step.sv
module cna_div_step (
  input  logic          clk_i,
  input  logic          en_i,
  input  cna_pkg::div_t d_i,
  output cna_pkg::div_t d_o
);
  import cna_pkg::*;

  logic             bit_re;
  logic             bit_im;
  div_t             d_d;
  div_t             d_q;

  // One restoring step per lane against the shared shifted divisor.
  always_comb begin
    bit_re       = {{(SH_W-NUM_W){1'b0}}, d_i.rem_re} >= d_i.dsh;
    bit_im       = {{(SH_W-NUM_W){1'b0}}, d_i.rem_im} >= d_i.dsh;
    d_d.rem_re   = bit_re ? d_i.rem_re - d_i.dsh[NUM_W-1:0] : d_i.rem_re;
    d_d.rem_im   = bit_im ? d_i.rem_im - d_i.dsh[NUM_W-1:0] : d_i.rem_im;
    d_d.quo_re   = {d_i.quo_re[QUO_W-2:0], bit_re};
    d_d.quo_im   = {d_i.quo_im[QUO_W-2:0], bit_im};
    d_d.dsh      = d_i.dsh >> 1;
  end

  // Stage register, advanced with the rest of the pipeline.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

// File: src/complex_number_alu_unit.sv
// Complex arithmetic unit on signed Q8.8 operands.
// Slave channel: s_axis_tdata_i carries a_real, a_imag, b_real, b_imag
// (lowest bits first) and s_axis_tuser_i carries the operation select
// (add, subtract, multiply, divide). A request is taken when tvalid and
// tready are both high.
// Master channel: m_axis_tdata_o carries res_real and res_imag, and
// m_axis_tuser_o carries the status and comparison flags.
// Every request yields exactly one result, in order.
// From acceptance to tvalid on the master side, a request passes through
// three stages of products, sums and operand preparation, 17 stages of
// the pipelined divider (one quotient bit per stage, run for every
// operation so all items share one path) and the output register.
// Throughput is one request per cycle while the receiver takes results.
// When the receiver stalls, the whole pipeline holds; tready drops only
// while a result waits in the output register and is not taken.
// Reset clears all valid bits, so the unit is ready as soon as reset is applied.
module complex_number_alu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // a_real[15:0], a_imag[31:16], b_real[47:32], b_imag[63:48]
  input  logic [63:0] s_axis_tdata_i,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // res_real[15:0], res_imag[31:16]
  output logic [31:0] m_axis_tdata_o,
  // div_by_zero[0], overflow[1], is_equal[2], is_greater[3], is_less[4],
  // greater_or_equal[5], less_or_equal[6]
  output logic [6:0]  m_axis_tuser_o
);
  import cna_pkg::*;

  typedef struct packed {
    logic              is_div;
    logic              dz;
    logic              eq;
    logic              gt;
    logic              lt;
    logic [DATA_W-1:0] fast_re;
    logic [DATA_W-1:0] fast_im;
    logic              fast_ovf;
    logic              neg_re;
    logic              neg_im;
    logic              big_re;
    logic              big_im;
  } side_t;

  logic en;

  logic signed [DATA_W-1:0] ar, ai, br, bi;

  // Stage 1 registers.
  logic                     v1_q;
  func_e                    func1_q;
  logic                     eq1_q;
  logic signed [DATA_W:0]   as_re1_q, as_im1_q;
  logic signed [PROD_W-1:0] arbr1_q, aibi1_q, arbi1_q, aibr1_q;
  logic signed [PROD_W-1:0] arar1_q, aiai1_q, brbr1_q, bibi1_q;

  // Stage 2 registers.
  logic                     v2_q;
  func_e                    func2_q;
  logic                     eq2_q;
  logic signed [DATA_W:0]   as_re2_q, as_im2_q;
  logic signed [SUM_W-1:0]  mul_re2_q, mul_im2_q, dn_re2_q, dn_im2_q;
  logic [DEN_W-1:0]         den2_q, mag_a2_q, mag_b2_q;

  // Stage 3 combinational preparation.
  logic signed [SUM_W-1:0]  fast_full_re, fast_full_im;
  logic [DATA_W-1:0]        fast_re, fast_im;
  logic                     fast_ovf_re, fast_ovf_im;
  logic signed [NUM_W-1:0]  num_re, num_im;
  logic [NUM_W-1:0]         abs_re, abs_im;
  side_t                    side3_d;
  div_t                     div3_d;

  // Divider pipeline and its side payload.
  logic                     vp_q [0:QUO_W];
  side_t                    side_q [0:QUO_W];
  div_t                     div_s [0:QUO_W];

  // Output stage.
  logic                     out_vld_q;
  logic [DATA_W-1:0]        res_re_d, res_im_d, res_re_q, res_im_q;
  logic                     ovf_d;
  logic [6:0]               flags_d, flags_q;
  logic                     ovf_q_re, ovf_q_im;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign ar = s_axis_tdata_i[15:0];
  assign ai = s_axis_tdata_i[31:16];
  assign br = s_axis_tdata_i[47:32];
  assign bi = s_axis_tdata_i[63:48];

  // Saturate a wide signed value to the result width.
  function automatic logic [DATA_W:0] sat_w(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] max_v;
    logic signed [SUM_W-1:0] min_v;
    max_v = SUM_W'((1 << (DATA_W - 1)) - 1);
    min_v = -SUM_W'(1 << (DATA_W - 1));
    if (v > max_v) begin
      sat_w = {1'b1, max_v[DATA_W-1:0]};
    end else if (v < min_v) begin
      sat_w = {1'b1, min_v[DATA_W-1:0]};
    end else begin
      sat_w = {1'b0, v[DATA_W-1:0]};
    end
  endfunction

  // Apply the sign to a quotient magnitude and saturate.
  function automatic logic [DATA_W:0] sat_q(input logic [QUO_W-1:0] q,
                                            input logic neg, input logic big);
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] neg_q;
    lim   = neg ? QUO_W'(1 << (DATA_W - 1)) : QUO_W'((1 << (DATA_W - 1)) - 1);
    neg_q = -q;
    if (big || q > lim) begin
      sat_q = {1'b1, neg ? lim[DATA_W-1:0] : lim[DATA_W-1:0]};
    end else begin
      sat_q = {1'b0, neg ? neg_q[DATA_W-1:0] : q[DATA_W-1:0]};
    end
  endfunction

  // Stage 1: partial products, add or subtract, equality.
  always_ff @(posedge clk_i) begin
    if (en) begin
      func1_q  <= func_e'(s_axis_tuser_i);
      eq1_q    <= (ar == br) && (ai == bi);
      if (func_e'(s_axis_tuser_i) == FUNC_SUB) begin
        as_re1_q <= (DATA_W+1)'(ar) - (DATA_W+1)'(br);
        as_im1_q <= (DATA_W+1)'(ai) - (DATA_W+1)'(bi);
      end else begin
        as_re1_q <= (DATA_W+1)'(ar) + (DATA_W+1)'(br);
        as_im1_q <= (DATA_W+1)'(ai) + (DATA_W+1)'(bi);
      end
      arbr1_q  <= ar * br;
      aibi1_q  <= ai * bi;
      arbi1_q  <= ar * bi;
      aibr1_q  <= ai * br;
      arar1_q  <= ar * ar;
      aiai1_q  <= ai * ai;
      brbr1_q  <= br * br;
      bibi1_q  <= bi * bi;
    end
  end

  // Stage 2: sums of products and magnitudes.
  always_ff @(posedge clk_i) begin
    if (en) begin
      func2_q   <= func1_q;
      eq2_q     <= eq1_q;
      as_re2_q  <= as_re1_q;
      as_im2_q  <= as_im1_q;
      mul_re2_q <= SUM_W'(arbr1_q) - SUM_W'(aibi1_q);
      mul_im2_q <= SUM_W'(arbi1_q) + SUM_W'(aibr1_q);
      dn_re2_q  <= SUM_W'(arbr1_q) + SUM_W'(aibi1_q);
      dn_im2_q  <= SUM_W'(aibr1_q) - SUM_W'(arbi1_q);
      den2_q    <= $unsigned(brbr1_q) + $unsigned(bibi1_q);
      mag_a2_q  <= $unsigned(arar1_q) + $unsigned(aiai1_q);
      mag_b2_q  <= $unsigned(brbr1_q) + $unsigned(bibi1_q);
    end
  end

  // Stage 3: saturate the direct results and set up the divider.
  always_comb begin
    if (func2_q == FUNC_MUL) begin
      fast_full_re = mul_re2_q >>> FRAC_BITS;
      fast_full_im = mul_im2_q >>> FRAC_BITS;
    end else begin
      fast_full_re = SUM_W'(as_re2_q);
      fast_full_im = SUM_W'(as_im2_q);
    end
    {fast_ovf_re, fast_re} = sat_w(fast_full_re);
    {fast_ovf_im, fast_im} = sat_w(fast_full_im);

    num_re = {dn_re2_q, {FRAC_BITS{1'b0}}};
    num_im = {dn_im2_q, {FRAC_BITS{1'b0}}};
    abs_re = num_re[NUM_W-1] ? $unsigned(-num_re) : $unsigned(num_re);
    abs_im = num_im[NUM_W-1] ? $unsigned(-num_im) : $unsigned(num_im);

    side3_d.is_div   = (func2_q == FUNC_DIV);
    side3_d.dz       = (func2_q == FUNC_DIV) && (den2_q == '0);
    side3_d.eq       = eq2_q;
    side3_d.gt       = mag_a2_q > mag_b2_q;
    side3_d.lt       = mag_a2_q < mag_b2_q;
    side3_d.fast_re  = fast_re;
    side3_d.fast_im  = fast_im;
    side3_d.fast_ovf = fast_ovf_re || fast_ovf_im;
    side3_d.neg_re   = num_re[NUM_W-1];
    side3_d.neg_im   = num_im[NUM_W-1];
    side3_d.big_re   = {{(CMP_W-NUM_W){1'b0}}, abs_re} >= {den2_q, {QUO_W{1'b0}}};
    side3_d.big_im   = {{(CMP_W-NUM_W){1'b0}}, abs_im} >= {den2_q, {QUO_W{1'b0}}};

    div3_d.dsh    = {den2_q, {(QUO_W-1){1'b0}}};
    div3_d.rem_re = abs_re;
    div3_d.rem_im = abs_im;
    div3_d.quo_re = '0;
    div3_d.quo_im = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side3_d;
      div_s[0]  <= div3_d;
    end
  end

  // Divider stages, one quotient bit each.
  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    cna_div_step u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (div_s[g]),
      .d_o   (div_s[g+1])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[g+1] <= side_q[g];
      end
    end
  end

  // Final selection of the result.
  always_comb begin
    {ovf_q_re, res_re_d} = sat_q(div_s[QUO_W].quo_re, side_q[QUO_W].neg_re,
                                 side_q[QUO_W].big_re);
    {ovf_q_im, res_im_d} = sat_q(div_s[QUO_W].quo_im, side_q[QUO_W].neg_im,
                                 side_q[QUO_W].big_im);
    ovf_d = ovf_q_re || ovf_q_im;
    if (!side_q[QUO_W].is_div) begin
      res_re_d = side_q[QUO_W].fast_re;
      res_im_d = side_q[QUO_W].fast_im;
      ovf_d    = side_q[QUO_W].fast_ovf;
    end else if (side_q[QUO_W].dz) begin
      res_re_d = '0;
      res_im_d = '0;
      ovf_d    = 1'b0;
    end
    flags_d = {side_q[QUO_W].eq || side_q[QUO_W].lt,
               side_q[QUO_W].eq || side_q[QUO_W].gt,
               side_q[QUO_W].lt, side_q[QUO_W].gt, side_q[QUO_W].eq,
               ovf_d, side_q[QUO_W].dz};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      flags_q  <= flags_d;
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i <= QUO_W; i++) begin
        vp_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q      <= s_axis_tvalid_i;
      v2_q      <= v1_q;
      vp_q[0]   <= v2_q;
      for (int i = 0; i < QUO_W; i++) begin
        vp_q[i+1] <= vp_q[i];
      end
      out_vld_q <= vp_q[QUO_W];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {res_im_q, res_re_q};
  assign m_axis_tuser_o  = flags_q;

  // A division by zero returns zero without overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0 && !m_axis_tuser_o[1])
    else $error("division by zero result not cleared");

  // Greater and less never hold together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[3] && m_axis_tuser_o[4]))
    else $error("greater and less both set");

  // Equal operands have equal magnitudes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |-> !m_axis_tuser_o[3] && !m_axis_tuser_o[4])
    else $error("equal operands report a magnitude difference");

  // An empty output register never blocks new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("pipeline stalled with an empty output");

  // A stalled result does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && m_axis_tvalid_o)
    else $error("stalled result changed");

endmodule

// File: tb/complex_number_alu_unit_tb.sv
`timescale 1ns / 1ps
module complex_number_alu_unit_tb;
  import cna_pkg::*;

  // Operand and result records at the block's widths.
  typedef struct packed {
    func_e             func;
    logic signed [15:0] a_real;
    logic signed [15:0] a_imag;
    logic signed [15:0] b_real;
    logic signed [15:0] b_imag;
  } operands_t;

  typedef struct packed {
    logic signed [15:0] res_real;
    logic signed [15:0] res_imag;
    logic div_by_zero;
    logic overflow;
    logic is_equal;
    logic is_greater;
    logic is_less;
    logic greater_or_equal;
    logic less_or_equal;
  } outcome_t;

  localparam int LATENCY = 21;
  localparam longint CYCLE_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [6:0]  m_axis_tuser_o;

  outcome_t pending_results[$];
  int       failures = 0;
  int       rx_wait = 0;
  longint   cycle_count = 0;

  complex_number_alu_unit uut (.*);

  // Free-running clock.
  always #2 clk_i = ~clk_i;

  // Clamp one part to 16 bits and note any saturation.
  function automatic logic signed [15:0] clamp16(input longint v, inout logic ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 16'sd32767;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  // Expected result of one complex operation.
  function automatic outcome_t complex_result(input operands_t op);
    outcome_t r;
    longint ar, ai, br, bi, re, im, den, mag_a, mag_b;
    logic ovf;
    ar = op.a_real;
    ai = op.a_imag;
    br = op.b_real;
    bi = op.b_imag;
    re = 0;
    im = 0;
    ovf = 1'b0;
    r = '0;
    case (op.func)
      FUNC_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      FUNC_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      FUNC_MUL: begin
        // Arithmetic shift floors toward minus infinity.
        re = (ar * br - ai * bi) >>> FRAC_BITS;
        im = (ar * bi + ai * br) >>> FRAC_BITS;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          // Integer division truncates toward zero.
          re = ((ar * br + ai * bi) * (64'sd1 <<< FRAC_BITS)) / den;
          im = ((ai * br - ar * bi) * (64'sd1 <<< FRAC_BITS)) / den;
        end
      end
    endcase
    r.res_real = clamp16(re, ovf);
    r.res_imag = clamp16(im, ovf);
    r.overflow = ovf;
    mag_a = ar * ar + ai * ai;
    mag_b = br * br + bi * bi;
    r.is_equal = (ar == br) && (ai == bi);
    r.is_greater = mag_a > mag_b;
    r.is_less = mag_a < mag_b;
    r.greater_or_equal = r.is_equal || r.is_greater;
    r.less_or_equal = r.is_equal || r.is_less;
    return r;
  endfunction

  // Send one request after a random gap and record its expected result.
  task automatic send_request(input operands_t op);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {op.b_imag, op.b_real, op.a_imag, op.a_real};
    s_axis_tuser_i <= op.func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(complex_result(op));
  endtask

  // Drop the request valid once the sender has nothing more to offer.
  task automatic release_bus();
    s_axis_tvalid_i <= 1'b0;
  endtask

  function automatic operands_t make_op(input func_e f, input int ar, input int ai,
                                        input int br, input int bi);
    operands_t op;
    op.func = f;
    op.a_real = ar[15:0];
    op.a_imag = ai[15:0];
    op.b_real = br[15:0];
    op.b_imag = bi[15:0];
    return op;
  endfunction

  // Random 16-bit value, biased toward extremes and small magnitudes.
  function automatic int pick_part();
    case ($urandom_range(0, 5))
      0: return 32767;
      1: return -32768;
      2: return $signed(16'($urandom_range(0, 1023) - 512));
      default: return $signed(16'($urandom));
    endcase
  endfunction

  // Receiver with random idle cycles and field-by-field comparison.
  always @(posedge clk_i) begin
    outcome_t got, want;
    int wait_n;
    cycle_count <= cycle_count + 1;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[15:0], m_axis_tdata_o[31:16], m_axis_tuser_o[0],
             m_axis_tuser_o[1], m_axis_tuser_o[2], m_axis_tuser_o[3],
             m_axis_tuser_o[4], m_axis_tuser_o[5], m_axis_tuser_o[6]};
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", got);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.res_real !== want.res_real) begin
          $error("res_real expected %0d actual %0d", want.res_real, got.res_real);
          failures++;
        end
        if (got.res_imag !== want.res_imag) begin
          $error("res_imag expected %0d actual %0d", want.res_imag, got.res_imag);
          failures++;
        end
        if (got.div_by_zero !== want.div_by_zero) begin
          $error("div_by_zero expected %b actual %b", want.div_by_zero, got.div_by_zero);
          failures++;
        end
        if (got.overflow !== want.overflow) begin
          $error("overflow expected %b actual %b", want.overflow, got.overflow);
          failures++;
        end
        if (got.is_equal !== want.is_equal) begin
          $error("is_equal expected %b actual %b", want.is_equal, got.is_equal);
          failures++;
        end
        if (got.is_greater !== want.is_greater) begin
          $error("is_greater expected %b actual %b", want.is_greater, got.is_greater);
          failures++;
        end
        if (got.is_less !== want.is_less) begin
          $error("is_less expected %b actual %b", want.is_less, got.is_less);
          failures++;
        end
        if (got.greater_or_equal !== want.greater_or_equal) begin
          $error("greater_or_equal expected %b actual %b", want.greater_or_equal,
                 got.greater_or_equal);
          failures++;
        end
        if (got.less_or_equal !== want.less_or_equal) begin
          $error("less_or_equal expected %b actual %b", want.less_or_equal,
                 got.less_or_equal);
          failures++;
        end
      end
      // Draw how many cycles the receiver idles before the next result.
      wait_n = $urandom_range(0, 3);
      rx_wait <= wait_n;
      m_axis_tready_i <= (wait_n == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready_i <= (rx_wait == 1);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("complex_number_alu_unit verification failed");
      $finish;
    end
  end

  // Directed extremes, every operation and the special cases.
  task automatic test_directed();
    send_request(make_op(FUNC_ADD, 32767, 32767, 32767, 32767));
    send_request(make_op(FUNC_ADD, -32768, -32768, -32768, -32768));
    send_request(make_op(FUNC_SUB, -32768, 32767, 32767, -32768));
    send_request(make_op(FUNC_SUB, 256, -256, 256, -256));
    send_request(make_op(FUNC_MUL, 256, 0, 256, 0));
    send_request(make_op(FUNC_MUL, -32768, -32768, -32768, -32768));
    send_request(make_op(FUNC_MUL, 32767, -32768, -32768, 32767));
    send_request(make_op(FUNC_MUL, -1, 0, 1, 0));
    send_request(make_op(FUNC_DIV, 256, 256, 0, 0));
    send_request(make_op(FUNC_DIV, 0, 0, 0, 0));
    send_request(make_op(FUNC_DIV, 32767, 32767, 1, 0));
    send_request(make_op(FUNC_DIV, -32768, -32768, -32768, -32768));
    send_request(make_op(FUNC_DIV, -1, 0, 3, 0));
    send_request(make_op(FUNC_DIV, 1, 1, -32768, 32767));
    send_request(make_op(FUNC_DIV, 0, 0, 0, 1));
    send_request(make_op(FUNC_ADD, 3, 4, 4, 3));
    send_request(make_op(FUNC_SUB, 3, 4, 5, 0));
    send_request(make_op(FUNC_MUL, 1, 2, 3, 4));
  endtask

  // Hold the sender until the pipeline has drained.
  task automatic test_drain_pause();
    release_bus();
    while (pending_results.size() != 0) @(posedge clk_i);
    send_request(make_op(FUNC_DIV, 100, -200, 7, 9));
  endtask

  // Random operations with random operands.
  task automatic test_random(input int count);
    operands_t op;
    int br, bi;
    repeat (count) begin
      br = pick_part();
      bi = pick_part();
      op = make_op(func_e'($urandom_range(0, 3)), pick_part(), pick_part(), br, bi);
      case ($urandom_range(0, 15))
        0: begin
          op.b_real = '0;
          op.b_imag = '0;
        end
        1: begin
          op.b_real = op.a_real;
          op.b_imag = op.a_imag;
        end
        2: begin
          op.b_real = op.a_imag;
          op.b_imag = op.a_real;
        end
        default: ;
      endcase
      send_request(op);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(450);
    test_drain_pause();
    test_random(480);
    release_bus();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (failures == 0) begin
      $display("complex_number_alu_unit verification clean");
    end else begin
      $display("complex_number_alu_unit verification failed");
    end
    $finish;
  end

endmodule

// File: complex_number_alu_unit.f
src/cna_pkg.sv
src/cna_div_step.sv
src/complex_number_alu_unit.sv
tb/complex_number_alu_unit_tb.sv
